// ----- rtl/ard_pkg.sv -----
// Shared types, constants and helper functions for the ARGB1555 run decoder.
// No dependencies; ard_div and the top level in rtl/ import this package.
package ard_pkg;

  // Field widths fixed by the stream format.
  localparam int WORD_W  = 16;
  localparam int SIDE_W  = 11;
  localparam int PIX_W   = 21;
  localparam int LEN_W   = 14;
  localparam int COLOR_W = 32;
  localparam int KIND_W  = 2;
  localparam int CNT_W   = $clog2(PIX_W);

  // Largest usable image side and the register values after reset.
  localparam logic [SIDE_W-1:0] MAX_SIDE     = SIDE_W'(1024);
  localparam logic [SIDE_W-1:0] WIDTH_RESET  = SIDE_W'(480);
  localparam logic [SIDE_W-1:0] HEIGHT_RESET = SIDE_W'(272);

  // Configuration register indexes.
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_RUN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUM = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR = 2'd2;

  // Word decoding masks.
  localparam logic [WORD_W-1:0] OPAQUE_BIT = 16'h8000;
  localparam logic [WORD_W-1:0] RUN_MASK   = 16'hc000;
  localparam logic [WORD_W-1:0] COUNT_MASK = 16'h3fff;
  localparam logic [4:0]        CHAN_MASK  = 5'h1f;
  localparam logic [COLOR_W-1:0] ALPHA_FULL = 32'hff000000;

  typedef struct packed {
    logic [WORD_W-1:0] stream_word;
    logic              first_word;
    logic              last_word;
  } ard_in_t;

  typedef struct packed {
    logic [KIND_W-1:0]  result_kind;
    logic [PIX_W-1:0]   run_start;
    logic [LEN_W-1:0]   run_length;
    logic [COLOR_W-1:0] run_color;
    logic [SIDE_W-1:0]  box_left;
    logic [SIDE_W-1:0]  box_right;
    logic [SIDE_W-1:0]  box_top;
    logic [SIDE_W-1:0]  box_bottom;
    logic               all_visible;
    logic               last_result;
  } ard_out_t;

  // Clamp a programmed side length into 1..MAX_SIDE.
  function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) r = SIDE_W'(1);
    else if (v > MAX_SIDE) r = MAX_SIDE;
    return r;
  endfunction

  // Widen an ARGB1555 word to ARGB8888; transparent words give zero.
  function automatic logic [COLOR_W-1:0] widen_color(input logic [WORD_W-1:0] w);
    logic [7:0] r8, g8, b8;
    r8 = {w[14:10] & CHAN_MASK, 3'b000};
    g8 = {w[9:5] & CHAN_MASK, 3'b000};
    b8 = {w[4:0] & CHAN_MASK, 3'b000};
    if ((w & OPAQUE_BIT) == '0) return '0;
    return ALPHA_FULL | {8'h00, r8, g8, b8};
  endfunction

endpackage

// ----- rtl/ard_stream_if.sv -----
// Valid/ready stream channel carrying one payload struct per request.
// Depends on nothing; the payload type is given where the channel is instantiated.
interface ard_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/ard_div.sv -----
// Iterative restoring divider: pixel index by image width, one quotient bit a cycle.
// Depends on ard_pkg for the field widths.
module ard_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ard_pkg::PIX_W-1:0]  dividend_i,
  input  logic [ard_pkg::SIDE_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [ard_pkg::PIX_W-1:0]  quot_o,
  output logic [ard_pkg::SIDE_W-1:0] rem_o
);
  import ard_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PIX_W-1:0]  quo_q, quo_d;
  logic [SIDE_W-1:0] rem_q, rem_d;
  logic [SIDE_W:0]   trial;
  logic              ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem_q, quo_q[PIX_W-1]};
  assign ge    = trial >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[PIX_W-2:0], ge};
      rem_d = ge ? SIDE_W'(trial - {1'b0, divisor_i}) : trial[SIDE_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(PIX_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/argb1555_run_decoder_with_bounds_top.sv -----
// Top level of the ARGB1555 run decoder: config registers, sequencer, bounds and output register.
// Depends on ard_pkg, ard_stream_if and ard_div.
//
//   channel   direction  payload    accepted when
//   in_i      sink       ard_in_t   in_i.valid && in_i.ready
//   out_o     source     ard_out_t  out_o.valid && out_o.ready
//   cfg_*_i   write      11 bits    cfg_we_i
//
// A word is taken only while the sequencer is idle. Zero words, run opcodes, errors and
// transparent colours go from evaluation straight to the emit state, held there by output
// stalls. An opaque colour word needs the row and column of both run ends from the shared
// 21-bit divider, so it passes through both division states and the box state first.
// Reset clears all frame state; no clearing pass is needed.
// A stalled output holds the sequencer in its emit state.
module argb1555_run_decoder_with_bounds_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [ard_pkg::SIDE_W-1:0] cfg_wdata_i,
  ard_stream_if.sink                 in_i,
  ard_stream_if.source               out_o
);
  import ard_pkg::*;

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DIV0 = 3'd2;
  localparam logic [2:0] S_DIV1 = 3'd3;
  localparam logic [2:0] S_BOX  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [SIDE_W-1:0]  width_q, height_q;
  logic [SIDE_W-1:0]  eff_w, eff_h;
  logic [PIX_W-1:0]   total_q;

  // Frame state.
  logic [PIX_W-1:0]   pixel_q, pixel_d;
  logic               await_q, await_d;
  logic [LEN_W-1:0]   pend_q, pend_d;
  logic [SIDE_W-1:0]  left_q, left_d, right_q, right_d;
  logic [SIDE_W-1:0]  top_q, top_d, bottom_q, bottom_d;
  logic               vis_q, vis_d;
  logic               halt_q, halt_d;

  // Latched request and pending result.
  ard_in_t            word_q;
  logic               emit_main_q, emit_main_d, emit_sum_q, emit_sum_d;
  logic [KIND_W-1:0]  res_kind_q, res_kind_d;
  logic [PIX_W-1:0]   res_start_q, res_start_d;
  logic [LEN_W-1:0]   res_len_q, res_len_d;
  logic [COLOR_W-1:0] res_color_q, res_color_d;
  logic [SIDE_W-1:0]  y0_q, x0_q;

  // Output register.
  logic               out_valid_q;
  ard_out_t           out_data_q, out_data_d;
  logic               out_load;

  // Divider hookup.
  logic               div_start, div_done;
  logic [PIX_W-1:0]   div_dividend, div_quot;
  logic [SIDE_W-1:0]  div_rem;

  // Evaluation helpers.
  logic               in_accept;
  logic [PIX_W-1:0]   avail, run_end, run_last;
  logic [LEN_W-1:0]   clip_len;
  logic [COLOR_W-1:0] color;
  logic               same_row;
  logic [SIDE_W-1:0]  x0_eff, x1_eff, y1;

  assign eff_w = eff_side(width_q);
  assign eff_h = eff_side(height_q);

  // Configuration registers and the registered pixel total.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      total_q  <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_IDX_WIDTH) width_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == CFG_IDX_HEIGHT) height_q <= cfg_wdata_i;
      total_q <= PIX_W'(eff_w) * PIX_W'(eff_h);
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;

  // Run clipping and colour for a colour word.
  assign avail    = (pixel_q < total_q) ? total_q - pixel_q : '0;
  assign clip_len = ({{(PIX_W-LEN_W){1'b0}}, pend_q} > avail) ? LEN_W'(avail) : pend_q;
  assign color    = widen_color(word_q.stream_word);
  assign run_end  = res_start_q + {{(PIX_W-LEN_W){1'b0}}, res_len_q};
  assign run_last = run_end - PIX_W'(1);

  // Divider operand: run start first, last pixel of the run second.
  assign div_start    = (state_q == S_EVAL && !halt_q && await_q && clip_len != '0
                         && color != '0) || (state_q == S_DIV0 && div_done);
  assign div_dividend = (state_q == S_EVAL) ? pixel_q : run_last;

  ard_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (eff_w),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Bounding box columns of the run end under evaluation.
  assign y1       = div_quot[SIDE_W-1:0];
  assign same_row = (y0_q == y1);
  assign x0_eff   = same_row ? x0_q : '0;
  assign x1_eff   = same_row ? div_rem + SIDE_W'(1) : eff_w;

  // Output register load.
  assign out_load = (state_q == S_EMIT) && (emit_main_q || emit_sum_q)
                    && (!out_valid_q || out_o.ready);

  always_comb begin
    out_data_d             = out_data_q;
    out_data_d.box_left    = left_q;
    out_data_d.box_right   = right_q;
    out_data_d.box_top     = top_q;
    out_data_d.box_bottom  = bottom_q;
    out_data_d.all_visible = vis_q && (pixel_q == total_q);
    if (emit_main_q) begin
      out_data_d.result_kind = res_kind_q;
      out_data_d.run_start   = res_start_q;
      out_data_d.run_length  = res_len_q;
      out_data_d.run_color   = res_color_q;
      out_data_d.last_result = !emit_sum_q;
    end else begin
      out_data_d.result_kind = KIND_SUM;
      out_data_d.run_start   = pixel_q;
      out_data_d.run_length  = '0;
      out_data_d.run_color   = '0;
      out_data_d.last_result = 1'b1;
    end
  end

  // Sequencer and frame state update.
  always_comb begin
    state_d     = state_q;
    pixel_d     = pixel_q;
    await_d     = await_q;
    pend_d      = pend_q;
    left_d      = left_q;
    right_d     = right_q;
    top_d       = top_q;
    bottom_d    = bottom_q;
    vis_d       = vis_q;
    halt_d      = halt_q;
    emit_main_d = emit_main_q;
    emit_sum_d  = emit_sum_q;
    res_kind_d  = res_kind_q;
    res_start_d = res_start_q;
    res_len_d   = res_len_q;
    res_color_d = res_color_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EVAL;
          // A first word restarts the frame before it is decoded.
          if (in_i.payload.first_word) begin
            pixel_d  = '0;
            await_d  = 1'b0;
            pend_d   = '0;
            left_d   = eff_w;
            right_d  = '0;
            top_d    = eff_h;
            bottom_d = '0;
            vis_d    = 1'b1;
            halt_d   = 1'b0;
          end
        end
      end
      S_EVAL: begin
        emit_main_d = 1'b0;
        res_kind_d  = KIND_RUN;
        res_start_d = pixel_q;
        res_len_d   = '0;
        res_color_d = '0;
        state_d     = S_EMIT;
        if (!halt_q) begin
          if (await_q) begin
            // Colour word closes a pending run.
            await_d     = 1'b0;
            emit_main_d = 1'b1;
            res_len_d   = clip_len;
            res_color_d = color;
            if (clip_len != '0) begin
              if (color != '0) begin
                state_d = S_DIV0;
              end else begin
                vis_d   = 1'b0;
                pixel_d = pixel_q + {{(PIX_W-LEN_W){1'b0}}, clip_len};
              end
            end
          end else if (pixel_q < total_q) begin
            if (word_q.stream_word == '0) begin
              // Single transparent pixel.
              emit_main_d = 1'b1;
              res_len_d   = LEN_W'(1);
              vis_d       = 1'b0;
              pixel_d     = pixel_q + PIX_W'(1);
            end else if ((word_q.stream_word & RUN_MASK) == RUN_MASK) begin
              await_d = 1'b1;
              pend_d  = LEN_W'(word_q.stream_word & COUNT_MASK);
            end else begin
              // Unknown opcode halts the frame.
              emit_main_d = 1'b1;
              res_kind_d  = KIND_ERR;
              halt_d      = 1'b1;
            end
          end
        end
        if (word_q.last_word) await_d = 1'b0;
        emit_sum_d = word_q.last_word && !halt_d;
      end
      S_DIV0: begin
        if (div_done) state_d = S_DIV1;
      end
      S_DIV1: begin
        if (div_done) state_d = S_BOX;
      end
      S_BOX: begin
        // Opaque run widens the bounding box.
        if (x0_eff < left_q) left_d = x0_eff;
        if (x1_eff > right_q) right_d = x1_eff;
        if (y0_q < top_q) top_d = y0_q;
        bottom_d = y1 + SIDE_W'(1);
        pixel_d  = run_end;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          if (emit_main_q) emit_main_d = 1'b0;
          else emit_sum_d = 1'b0;
        end
        if (!emit_main_q && !emit_sum_q) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pixel_q     <= '0;
      await_q     <= 1'b0;
      pend_q      <= '0;
      left_q      <= WIDTH_RESET;
      right_q     <= '0;
      top_q       <= HEIGHT_RESET;
      bottom_q    <= '0;
      vis_q       <= 1'b1;
      halt_q      <= 1'b0;
      emit_main_q <= 1'b0;
      emit_sum_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pixel_q     <= pixel_d;
      await_q     <= await_d;
      pend_q      <= pend_d;
      left_q      <= left_d;
      right_q     <= right_d;
      top_q       <= top_d;
      bottom_q    <= bottom_d;
      vis_q       <= vis_d;
      halt_q      <= halt_d;
      emit_main_q <= emit_main_d;
      emit_sum_q  <= emit_sum_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Payload registers: request latch, pending result, division results, output data.
  always_ff @(posedge clk_i) begin
    if (in_accept) word_q <= in_i.payload;
    res_kind_q  <= res_kind_d;
    res_start_q <= res_start_d;
    res_len_q   <= res_len_d;
    res_color_q <= res_color_d;
    if (state_q == S_DIV0 && div_done) begin
      y0_q <= div_quot[SIDE_W-1:0];
      x0_q <= div_rem;
    end
    if (out_load) out_data_q <= out_data_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

endmodule

// ----- tb/sv/argb1555_run_decoder_with_bounds_top_tb.sv -----
// Self-checking testbench for the ARGB1555 run decoder with bounding box.
// Depends on ard_pkg, ard_stream_if and the top level argb1555_run_decoder_with_bounds_top.
module argb1555_run_decoder_with_bounds_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ard_pkg::*;

  localparam int unsigned ITEM_GOAL     = 1100;
  localparam int unsigned SETTLE_CYCLES = 90;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned RUN_MAX       = 16383;

  logic clk_i;
  logic rst_n;
  logic cfg_we;
  logic cfg_idx;
  logic [SIDE_W-1:0] cfg_wdata;

  ard_stream_if #(.payload_t(ard_in_t))  word_ch ();
  ard_stream_if #(.payload_t(ard_out_t)) run_ch ();

  argb1555_run_decoder_with_bounds_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (word_ch),
    .out_o       (run_ch)
  );

  // Words waiting to be offered, and decoded results waiting to come out.
  ard_in_t  words_todo[$];
  ard_out_t runs_due[$];

  // Shadow of the geometry registers and of the frame state.
  logic [SIDE_W-1:0] width_reg;
  logic [SIDE_W-1:0] height_reg;
  int unsigned pix;
  int unsigned pend_len;
  int unsigned left_b;
  int unsigned right_b;
  int unsigned top_b;
  int unsigned bottom_b;
  bit          awaiting;
  bit          vis;
  bit          halted;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned cycle_count;
  int unsigned words_queued;
  int unsigned words_taken;
  int unsigned bad_fields;
  int unsigned runs_seen;
  int unsigned sums_seen;
  int unsigned errs_seen;
  int unsigned phase_count;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Clamp a programmed side into the usable range.
  function automatic int unsigned clamp_side(logic [SIDE_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_SIDE) return 32'(MAX_SIDE);
    return 32'(v);
  endfunction

  // ARGB1555 to ARGB8888; a clear top bit means fully transparent.
  function automatic logic [COLOR_W-1:0] argb8888(logic [WORD_W-1:0] w);
    if (!w[15]) return '0;
    return {8'hff, w[14:10], 3'b000, w[9:5], 3'b000, w[4:0], 3'b000};
  endfunction

  function automatic logic [WORD_W-1:0] run_op(int unsigned n);
    return RUN_MASK | (WORD_W'(n) & COUNT_MASK);
  endfunction

  function automatic void clear_frame();
    pix      = 0;
    awaiting = 1'b0;
    pend_len = 0;
    left_b   = clamp_side(width_reg);
    right_b  = 0;
    top_b    = clamp_side(height_reg);
    bottom_b = 0;
    vis      = 1'b1;
    halted   = 1'b0;
  endfunction

  function automatic void note_result(logic [KIND_W-1:0] kind, int unsigned start,
                                      int unsigned len, logic [COLOR_W-1:0] color,
                                      int unsigned total);
    ard_out_t r;
    r.result_kind = kind;
    r.run_start   = PIX_W'(start);
    r.run_length  = LEN_W'(len);
    r.run_color   = color;
    r.box_left    = SIDE_W'(left_b);
    r.box_right   = SIDE_W'(right_b);
    r.box_top     = SIDE_W'(top_b);
    r.box_bottom  = SIDE_W'(bottom_b);
    r.all_visible = vis && (pix == total);
    r.last_result = 1'b0;
    runs_due.push_back(r);
  endfunction

  // Advance the shadow decoder by one accepted word and queue what it produces.
  function automatic void decode_word(ard_in_t it);
    int unsigned w, h, total, len, avail, start, endp, y0, y1, x0, x1, n0;
    logic [COLOR_W-1:0] color;
    bit err_now;
    ard_out_t r;
    n0 = runs_due.size();
    err_now = 1'b0;
    if (it.first_word) clear_frame();
    w = clamp_side(width_reg);
    h = clamp_side(height_reg);
    total = w * h;
    if (!halted) begin
      if (awaiting) begin
        // Colour word closes the pending run, clipped at the end of the image.
        color = argb8888(it.stream_word);
        len = pend_len;
        avail = (pix < total) ? total - pix : 0;
        start = pix;
        awaiting = 1'b0;
        if (len > avail) len = avail;
        if (len != 0) begin
          endp = start + len;
          if (color != '0) begin
            y0 = start / w;
            y1 = (endp - 1) / w;
            x0 = (y0 == y1) ? start % w : 0;
            x1 = (y0 == y1) ? (endp - 1) % w + 1 : w;
            if (x0 < left_b) left_b = x0;
            if (x1 > right_b) right_b = x1;
            if (y0 < top_b) top_b = y0;
            bottom_b = y1 + 1;
          end else begin
            vis = 1'b0;
          end
          pix = endp;
        end
        note_result(KIND_RUN, start, len, color, total);
      end else if (pix < total) begin
        if (it.stream_word == '0) begin
          start = pix;
          vis = 1'b0;
          pix++;
          note_result(KIND_RUN, start, 1, '0, total);
        end else if ((it.stream_word & RUN_MASK) == RUN_MASK) begin
          awaiting = 1'b1;
          pend_len = 32'(it.stream_word & COUNT_MASK);
        end else begin
          halted = 1'b1;
          err_now = 1'b1;
          note_result(KIND_ERR, pix, 0, '0, total);
        end
      end
    end
    // The last word drops any half-open run and closes the frame.
    if (it.last_word) begin
      awaiting = 1'b0;
      if (!halted && !err_now) note_result(KIND_SUM, pix, 0, '0, total);
    end
    if (runs_due.size() > n0) begin
      r = runs_due.pop_back();
      r.last_result = 1'b1;
      runs_due.push_back(r);
    end
  endfunction

  function automatic void field_ok(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      bad_fields++;
    end
  endfunction

  function automatic void check_run(ard_out_t got);
    ard_out_t want;
    case (got.result_kind)
      KIND_RUN: runs_seen++;
      KIND_SUM: sums_seen++;
      default:  errs_seen++;
    endcase
    if (runs_due.size() == 0) begin
      $error("unexpected result: kind %0d start %0d", got.result_kind, got.run_start);
      bad_fields++;
    end else begin
      want = runs_due.pop_front();
      field_ok("result_kind", 64'(want.result_kind), 64'(got.result_kind));
      field_ok("run_start", 64'(want.run_start), 64'(got.run_start));
      field_ok("run_length", 64'(want.run_length), 64'(got.run_length));
      field_ok("run_color", 64'(want.run_color), 64'(got.run_color));
      field_ok("box_left", 64'(want.box_left), 64'(got.box_left));
      field_ok("box_right", 64'(want.box_right), 64'(got.box_right));
      field_ok("box_top", 64'(want.box_top), 64'(got.box_top));
      field_ok("box_bottom", 64'(want.box_bottom), 64'(got.box_bottom));
      field_ok("all_visible", 64'(want.all_visible), 64'(got.all_visible));
      field_ok("last_result", 64'(want.last_result), 64'(got.last_result));
    end
  endfunction

  // Request driver: offers queued words, with random bursts of idle cycles.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      word_ch.valid   <= 1'b0;
      word_ch.payload <= '0;
      send_gap        <= 0;
    end else begin
      if (word_ch.valid && word_ch.ready) begin
        decode_word(word_ch.payload);
        words_taken++;
      end
      if (!(word_ch.valid && !word_ch.ready)) begin
        if (send_gap != 0) begin
          word_ch.valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (words_todo.size() != 0) begin
          if ($urandom_range(0, 99) < send_idle_pct) begin
            word_ch.valid <= 1'b0;
            send_gap <= $urandom_range(0, 10);
          end else begin
            word_ch.valid   <= 1'b1;
            word_ch.payload <= words_todo.pop_front();
          end
        end else begin
          word_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks every accepted result and stalls in random bursts.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      run_ch.ready <= 1'b0;
      recv_gap     <= 0;
    end else begin
      if (run_ch.valid && run_ch.ready) check_run(run_ch.payload);
      if (recv_gap != 0) begin
        run_ch.ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else if ($urandom_range(0, 99) < recv_stall_pct) begin
        run_ch.ready <= 1'b0;
        recv_gap <= $urandom_range(0, 10);
      end else begin
        run_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, runs_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_word(logic [WORD_W-1:0] w, bit f, bit l);
    ard_in_t it;
    it.stream_word = w;
    it.first_word  = f;
    it.last_word   = l;
    words_todo.push_back(it);
    words_queued++;
  endtask

  task automatic set_reg(logic idx, logic [SIDE_W-1:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_WIDTH) width_reg = v;
    else height_reg = v;
    @(negedge clk_i);
  endtask

  // Wait until every word is taken and every result is back, then let the block drain.
  task automatic settle();
    @(negedge clk_i);
    while (words_todo.size() != 0 || word_ch.valid || runs_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic int unsigned pick_len(int unsigned room);
    int unsigned sel, cap;
    sel = $urandom_range(0, 99);
    cap = (room == 0) ? 1 : ((room > RUN_MAX) ? RUN_MAX : room);
    if (sel < 40) return $urandom_range(1, 8);
    if (sel < 70) return $urandom_range(1, cap);
    if (sel < 75) return RUN_MAX;
    return $urandom_range(0, RUN_MAX);
  endfunction

  // A frame of mixed words: runs, single transparent pixels, empty runs and bad opcodes.
  task automatic queue_frame(bit open_new);
    int unsigned total, done, steps, k, len, sel;
    bit f, l;
    total = clamp_side(width_reg) * clamp_side(height_reg);
    done = open_new ? 0 : pix;
    steps = $urandom_range(2, 24);
    for (k = 0; k < steps; k++) begin
      f = open_new && (k == 0);
      l = (k == steps - 1);
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        len = pick_len((total > done) ? total - done : 0);
        if (l && $urandom_range(0, 5) == 0) begin
          // Colour cut off by the end of the body.
          push_word(run_op(len), f, 1'b1);
        end else begin
          push_word(run_op(len), f, 1'b0);
          if ($urandom_range(0, 4) != 0)
            push_word(WORD_W'($urandom()) | OPAQUE_BIT, 1'b0, l);
          else
            push_word(WORD_W'($urandom()) & ~OPAQUE_BIT, 1'b0, l);
        end
        done += len;
      end else if (sel < 78) begin
        push_word('0, f, l);
        done++;
      end else if (sel < 84) begin
        push_word(run_op(0), f, 1'b0);
        push_word(WORD_W'($urandom()), 1'b0, l);
      end else if (sel < 90) begin
        push_word(WORD_W'($urandom_range(1, 16'hbfff)), f, l);
      end else begin
        push_word(WORD_W'($urandom()), f, l);
      end
    end
  endtask

  // A frame of opaque runs that fills the image exactly to its last pixel.
  task automatic queue_fill(bit open_new);
    int unsigned total, done, room, len;
    bit f;
    total = clamp_side(width_reg) * clamp_side(height_reg);
    done = open_new ? 0 : pix;
    f = open_new;
    while (done < total) begin
      room = total - done;
      if (room > RUN_MAX) room = RUN_MAX;
      len = $urandom_range(1, room);
      push_word(run_op(len), f, 1'b0);
      push_word(WORD_W'($urandom()) | OPAQUE_BIT, 1'b0, 1'b0);
      f = 1'b0;
      done += len;
    end
    push_word('0, f, 1'b1);
  endtask

  // New geometry for a phase, from tiny images up to the clamped extremes.
  task automatic pick_geometry();
    int unsigned sel, which;
    logic [SIDE_W-1:0] w, h;
    logic [SIDE_W-1:0] edges[5];
    edges = '{11'd0, 11'd1, 11'd1024, 11'd1025, 11'd2047};
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      w = 11'd1024;
      h = 11'd1024;
    end else if (sel == 1) begin
      w = edges[$urandom_range(0, 4)];
      h = edges[$urandom_range(0, 4)];
    end else if (sel < 7) begin
      w = SIDE_W'($urandom_range(1, 16));
      h = SIDE_W'($urandom_range(1, 16));
    end else if (sel < 9) begin
      w = SIDE_W'($urandom_range(17, 200));
      h = SIDE_W'($urandom_range(1, 64));
    end else begin
      w = SIDE_W'($urandom());
      h = SIDE_W'($urandom());
    end
    which = $urandom_range(0, 9);
    if (which != 9) set_reg(CFG_IDX_WIDTH, w);
    if (which != 8) set_reg(CFG_IDX_HEIGHT, h);
  endtask

  // Stimulus: directed frames first, then random phases of frames and noise.
  initial begin
    int unsigned pcts[4];
    int unsigned frames, n, total;
    bit quiet;
    pcts = '{0, 10, 30, 60};
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_IDX_WIDTH;
    cfg_wdata       = '0;
    width_reg       = WIDTH_RESET;
    height_reg      = HEIGHT_RESET;
    clear_frame();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Reset geometry: single pixel, empty run, longest run, transparent and
    // opaque colours, and a run whose colour is cut off by the last word.
    push_word(16'h0000, 1'b1, 1'b0);
    push_word(run_op(0), 1'b0, 1'b0);
    push_word(16'hffff, 1'b0, 1'b0);
    push_word(run_op(RUN_MAX), 1'b0, 1'b0);
    push_word(16'h8000, 1'b0, 1'b0);
    push_word(run_op(5), 1'b0, 1'b0);
    push_word(16'h7fff, 1'b0, 1'b0);
    push_word(run_op(3), 1'b0, 1'b0);
    push_word(16'h801f, 1'b0, 1'b0);
    push_word(run_op(16), 1'b0, 1'b1);
    // Decode error halts the frame until the next first word.
    push_word(16'h1234, 1'b1, 1'b0);
    push_word(16'h0000, 1'b0, 1'b0);
    push_word(16'h0000, 1'b0, 1'b1);
    push_word(16'h4000, 1'b1, 1'b1);
    settle();

    // One-pixel image: clipping, then words ignored once the image is full.
    set_reg(CFG_IDX_WIDTH, 11'd0);
    set_reg(CFG_IDX_HEIGHT, 11'd1);
    push_word(run_op(2), 1'b1, 1'b0);
    push_word(16'hffff, 1'b0, 1'b0);
    push_word(16'h0000, 1'b0, 1'b0);
    push_word(run_op(1), 1'b0, 1'b0);
    settle();

    // Grow the image mid-frame and cover the rest with one opaque run.
    set_reg(CFG_IDX_WIDTH, 11'd4);
    set_reg(CFG_IDX_HEIGHT, 11'd4);
    push_word(run_op(15), 1'b0, 1'b0);
    push_word(16'h83e0, 1'b0, 1'b0);
    push_word(16'h0000, 1'b0, 1'b1);
    settle();

    // Leave a run open, then shrink the image below the current pixel index.
    push_word(16'h0000, 1'b1, 1'b0);
    push_word(16'h0000, 1'b0, 1'b0);
    push_word(run_op(10), 1'b0, 1'b0);
    settle();
    set_reg(CFG_IDX_WIDTH, 11'd1);
    set_reg(CFG_IDX_HEIGHT, 11'd0);
    push_word(16'h801f, 1'b0, 1'b1);
    settle();

    // Random phases; the last part runs without idling on either side.
    while (words_queued < ITEM_GOAL) begin
      phase_count++;
      quiet = words_queued > (ITEM_GOAL * 85) / 100;
      send_idle_pct  = quiet ? 0 : pcts[$urandom_range(0, 3)];
      recv_stall_pct = quiet ? 0 : pcts[$urandom_range(0, 3)];
      if ($urandom_range(0, 3) != 0) pick_geometry();
      total = clamp_side(width_reg) * clamp_side(height_reg);
      frames = $urandom_range(1, 3);
      for (n = 0; n < frames; n++) begin
        if (total <= 4096 && $urandom_range(0, 3) == 0)
          queue_fill(!(n == 0 && $urandom_range(0, 4) == 0));
        else
          queue_frame(!(n == 0 && $urandom_range(0, 4) == 0));
      end
      if ($urandom_range(0, 4) == 0) begin
        for (n = 0; n < $urandom_range(3, 6); n++)
          push_word(WORD_W'($urandom()), $urandom_range(0, 7) == 0,
                    $urandom_range(0, 7) == 0);
      end
      settle();
    end

    if (runs_due.size() != 0)
      $error("%0d expected results never arrived", runs_due.size());
    $display("Fed %0d words over %0d random phases after the directed frames.",
             words_taken, phase_count);
    $display("Checked %0d runs, %0d summaries and %0d decode errors; %0d field mismatches.",
             runs_seen, sums_seen, errs_seen, bad_fields);
    if (bad_fields == 0 && runs_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
